// ----- src/elpc_pkg.sv -----
// Shared types and constants for the line-art eye pixel classifier.
// No dependencies; used by elpc_cfg and eye_lineart_pixel_classifier.
package elpc_pkg;

    // Width of the wide signed datapath that holds the scaled lid and
    // catchlight terms.
    localparam int WIDE = 60;

    // Configuration address width and register indexes.
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_EYE_CX     = 3'd0;
    localparam logic [2:0] REG_EYE_CY     = 3'd1;
    localparam logic [2:0] REG_PUPIL_OX   = 3'd2;
    localparam logic [2:0] REG_PUPIL_OY   = 3'd3;
    localparam logic [2:0] REG_PUPIL_SC   = 3'd4;
    localparam logic [2:0] REG_LID_DROOP  = 3'd5;
    localparam logic [2:0] REG_INNER_SH   = 3'd6;
    localparam logic [2:0] REG_OUTER_SH   = 3'd7;

    // Pixel class codes.
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_LINE  = 3'd1;
    localparam logic [2:0] CLS_IRIS  = 3'd2;
    localparam logic [2:0] CLS_PUPIL = 3'd3;
    localparam logic [2:0] CLS_CATCH = 3'd4;

    // Lid opening limits, in units of 1/6400.
    localparam logic signed [15:0] LID_NOMINAL = 16'sd6400;
    localparam logic signed [15:0] LID_MIN     = 16'sd256;
    localparam logic signed [15:0] LID_MAX     = 16'sd6720;

    // Configuration registers and the values derived from them.
    typedef struct packed {
        logic        [7:0]      eye_cx;
        logic        [7:0]      eye_cy;
        logic signed [8:0]      pupil_ox;
        logic signed [8:0]      pupil_oy;
        logic        [8:0]      pupil_sc;
        logic signed [8:0]      inner_sh;
        logic signed [8:0]      outer_sh;
        logic        [12:0]     lid_span;
        logic signed [WIDE-1:0] lid_base;
        logic        [31:0]     pupil_p;
        logic signed [WIDE-1:0] pupil_pp;
    } t_cfg;

endpackage

// ----- src/elpc_cfg.sv -----
// APB register file for the eye classifier, plus values derived from it.
// Depends on elpc_pkg.
module elpc_cfg
    import elpc_pkg::*;
#(
    parameter int RADIUS_PX = 35
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic        [7:0]  r_eye_cx, r_eye_cy;
    logic signed [8:0]  r_pupil_ox, r_pupil_oy, r_droop, r_inner, r_outer;
    logic        [8:0]  r_pupil_sc;
    logic        [12:0] r_lid_span;
    logic signed [WIDE-1:0] r_lid_base, r_pupil_pp;
    logic        [31:0] r_pupil_p;
    logic signed [15:0] lid_raw;
    logic        [12:0] n_lid_span;
    logic        [2:0]  reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_cx   <= 8'd82;
            r_eye_cy   <= 8'd120;
            r_pupil_ox <= '0;
            r_pupil_oy <= '0;
            r_pupil_sc <= 9'd256;
            r_droop    <= '0;
            r_inner    <= '0;
            r_outer    <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_EYE_CX:    r_eye_cx   <= pwdata[7:0];
                REG_EYE_CY:    r_eye_cy   <= pwdata[7:0];
                REG_PUPIL_OX:  r_pupil_ox <= pwdata[8:0];
                REG_PUPIL_OY:  r_pupil_oy <= pwdata[8:0];
                REG_PUPIL_SC:  r_pupil_sc <= pwdata[8:0];
                REG_LID_DROOP: r_droop    <= pwdata[8:0];
                REG_INNER_SH:  r_inner    <= pwdata[8:0];
                REG_OUTER_SH:  r_outer    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_EYE_CX:    prdata = 32'(r_eye_cx);
            REG_EYE_CY:    prdata = 32'(r_eye_cy);
            REG_PUPIL_OX:  prdata = 32'(unsigned'(r_pupil_ox));
            REG_PUPIL_OY:  prdata = 32'(unsigned'(r_pupil_oy));
            REG_PUPIL_SC:  prdata = 32'(r_pupil_sc);
            REG_LID_DROOP: prdata = 32'(unsigned'(r_droop));
            REG_INNER_SH:  prdata = 32'(unsigned'(r_inner));
            REG_OUTER_SH:  prdata = 32'(unsigned'(r_outer));
            default:       prdata = '0;
        endcase
    end

    // Lid opening L = 6400 - 40*droop, clamped.
    assign lid_raw = LID_NOMINAL - (16'sd40 * 16'(r_droop));
    always_comb begin
        if (lid_raw < LID_MIN) begin
            n_lid_span = 13'(LID_MIN);
        end else if (lid_raw > LID_MAX) begin
            n_lid_span = 13'(LID_MAX);
        end else begin
            n_lid_span = 13'(lid_raw);
        end
    end

    // Derived: lid span and pupil_p registered, then lid_base and pupil_pp.
    always_ff @(posedge i_clk) begin
        r_lid_span <= n_lid_span;
        r_lid_base <= WIDE'(8 * RADIUS_PX * RADIUS_PX * RADIUS_PX)
                      * $signed(WIDE'(r_lid_span));
        r_pupil_p  <= 32'(11 * RADIUS_PX) * 32'(r_pupil_sc);
        r_pupil_pp <= $signed(WIDE'(64'(r_pupil_p) * 64'(r_pupil_p)));
    end

    always_comb begin
        o_cfg.eye_cx   = r_eye_cx;
        o_cfg.eye_cy   = r_eye_cy;
        o_cfg.pupil_ox = r_pupil_ox;
        o_cfg.pupil_oy = r_pupil_oy;
        o_cfg.pupil_sc = r_pupil_sc;
        o_cfg.inner_sh = r_inner;
        o_cfg.outer_sh = r_outer;
        o_cfg.lid_span = r_lid_span;
        o_cfg.lid_base = r_lid_base;
        o_cfg.pupil_p  = r_pupil_p;
        o_cfg.pupil_pp = r_pupil_pp;
    end

endmodule

// ----- src/eye_lineart_pixel_classifier.sv -----
// Line-art eye pixel classifier, top level. Depends on elpc_pkg and elpc_cfg.
// A word passes through the pipeline stages, the last of which registers the
// class; o_done is the valid bit shifted alongside the word.
// Throughput: one word per cycle, set by a five-stage pipeline; busy stays low.
// Reset is synchronous, active low; it clears the valid bits and loads the
// register defaults. The receiver cannot stall; results are strobed by o_done.
module eye_lineart_pixel_classifier
    import elpc_pkg::*;
#(
    parameter int RADIUS_PX    = 35,
    parameter int SCREEN_WIDTH = 240
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        i_pixel_x,
    input  logic [7:0]        i_pixel_y,
    output logic              o_done,
    output logic [2:0]        o_pixel_class,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Scaled constants. All lid terms are the exact lid geometry divided by
    // 128 so that no compare needs rounding.
    localparam longint R    = RADIUS_PX;
    localparam longint RSQ  = R * R;
    localparam longint RIN  = (R - 2) * (R - 2);
    localparam longint KD   = 51200 * R * R;
    localparam longint RING_HI = 64 * R * R;
    localparam longint RING_LO = 64 * (R - 3) * (R - 3);

    t_cfg cfg;

    elpc_cfg #(
        .RADIUS_PX(RADIUS_PX)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The pipeline never stalls, so a word is taken in every cycle.
    assign busy = 1'b0;

    logic [4:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], start};
        end
    end

    // Stage 0: offsets from the eye centre and the off-screen check.
    logic signed [9:0] r_s0_fx, r_s0_fy;
    logic              r_s0_off;

    always_ff @(posedge i_clk) begin
        r_s0_fx  <= $signed({2'b0, i_pixel_x}) - $signed({2'b0, cfg.eye_cx});
        r_s0_fy  <= $signed({2'b0, i_pixel_y}) - $signed({2'b0, cfg.eye_cy});
        r_s0_off <= 32'(i_pixel_x) >= 32'(SCREEN_WIDTH);
    end

    // Stage 1: squares of the offsets, the lid tilt term and pupil offsets.
    logic        [17:0] r_s1_rsq;
    logic signed [31:0] r_s1_arc, r_s1_x;
    logic signed [15:0] r_s1_dx16, r_s1_dy16;
    logic signed [9:0]  r_s1_fx, r_s1_fy;
    logic               r_s1_off;

    always_ff @(posedge i_clk) begin
        r_s1_rsq  <= 18'(32'(r_s0_fx * r_s0_fx) + 32'(r_s0_fy * r_s0_fy));
        r_s1_arc  <= 32'(RSQ) - 32'(r_s0_fx) * 32'(r_s0_fx);
        r_s1_x    <= 32'(2 * R) * 32'(cfg.inner_sh)
                     + (32'(cfg.outer_sh) - 32'(cfg.inner_sh))
                     * (32'(r_s0_fx) + 32'(R));
        r_s1_dx16 <= 16'(r_s0_fx) * 16'sd16 - 16'(cfg.pupil_ox);
        r_s1_dy16 <= 16'(r_s0_fy) * 16'sd16 - 16'(cfg.pupil_oy);
        r_s1_fx   <= r_s0_fx;
        r_s1_fy   <= r_s0_fy;
        r_s1_off  <= r_s0_off;
    end

    // Stage 2: lid arc product, pupil distance, scaled row and catchlight
    // centre offsets. The catchlight offsets stay well inside 32 bits.
    logic signed [WIDE-1:0] r_s2_larc, r_s2_fyd, r_s2_rx250, r_s2_rx150;
    logic signed [31:0]     r_s2_cxp, r_s2_cyp;
    logic        [31:0]     r_s2_d16;
    logic                   r_s2_inside, r_s2_outline, r_s2_off;

    always_ff @(posedge i_clk) begin
        r_s2_larc    <= WIDE'(r_s1_arc) * $signed(WIDE'(cfg.lid_span));
        r_s2_d16     <= 32'(32'(r_s1_dx16) * 32'(r_s1_dx16))
                        + 32'(32'(r_s1_dy16) * 32'(r_s1_dy16));
        r_s2_fyd     <= WIDE'(KD) * WIDE'(r_s1_fy);
        r_s2_rx250   <= WIDE'(250 * R) * WIDE'(r_s1_x);
        r_s2_rx150   <= WIDE'(150 * R) * WIDE'(r_s1_x);
        r_s2_cxp     <= 32'sd256000 * 32'(r_s1_fx) - 32'sd16000 * 32'(cfg.pupil_ox)
                        + 32'sd6 * $signed(cfg.pupil_p);
        r_s2_cyp     <= 32'sd256000 * 32'(r_s1_fy) - 32'sd16000 * 32'(cfg.pupil_oy)
                        + 32'sd7 * $signed(cfg.pupil_p);
        r_s2_inside  <= 64'(r_s1_rsq) < 64'(RSQ);
        r_s2_outline <= 64'(r_s1_rsq) > 64'(RIN);
        r_s2_off     <= r_s1_off;
    end

    // Stage 3: lid edges, catchlight squares, iris and pupil compares.
    logic signed [WIDE-1:0] r_s3_top, r_s3_bot, r_s3_fyd, r_s3_cx2, r_s3_cy2;
    logic                   r_s3_ring, r_s3_pupil, r_s3_inside, r_s3_outline;
    logic                   r_s3_off;

    always_ff @(posedge i_clk) begin
        r_s3_top     <= r_s2_rx250 + r_s2_larc * WIDE'(32) - cfg.lid_base;
        r_s3_bot     <= cfg.lid_base - r_s2_larc * WIDE'(20) - r_s2_rx150;
        r_s3_cx2     <= WIDE'(r_s2_cxp) * WIDE'(r_s2_cxp);
        r_s3_cy2     <= WIDE'(r_s2_cyp) * WIDE'(r_s2_cyp);
        r_s3_ring    <= 64'(r_s2_d16) < 64'(RING_HI) && 64'(r_s2_d16) > 64'(RING_LO);
        r_s3_pupil   <= WIDE'(640000) * $signed(WIDE'(r_s2_d16)) < cfg.pupil_pp;
        r_s3_fyd     <= r_s2_fyd;
        r_s3_inside  <= r_s2_inside;
        r_s3_outline <= r_s2_outline;
        r_s3_off     <= r_s2_off;
    end

    // Stage 4: lid tests and the priority pick.
    logic signed [WIDE-1:0] d_top, d_bot, a_top, a_bot;
    logic                   near_lid, open_row, catch_hit;
    logic [2:0]             n_class, r_class;

    always_comb begin
        d_top     = r_s3_fyd - r_s3_top;
        d_bot     = r_s3_fyd - r_s3_bot;
        a_top     = (d_top < 0) ? -d_top : d_top;
        a_bot     = (d_bot < 0) ? -d_bot : d_bot;
        near_lid  = (a_top * WIDE'(10) < WIDE'(13 * KD))
                    || (a_bot * WIDE'(10) < WIDE'(13 * KD));
        open_row  = !(r_s3_fyd < r_s3_top) && !(r_s3_fyd > r_s3_bot);
        catch_hit = (r_s3_cx2 + r_s3_cy2) < cfg.pupil_pp * WIDE'(49);

        if (r_s3_off || !r_s3_inside || !open_row) begin
            n_class = CLS_NONE;
        end else if (r_s3_outline || near_lid) begin
            n_class = CLS_LINE;
        end else if (r_s3_ring) begin
            n_class = CLS_IRIS;
        end else if (r_s3_pupil) begin
            n_class = catch_hit ? CLS_CATCH : CLS_PUPIL;
        end else begin
            n_class = CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_class <= n_class;
    end

    assign o_done        = r_vld[4];
    assign o_pixel_class = r_class;

endmodule

// ----- tb/tb_eye_lineart_pixel_classifier.sv -----
// Self-checking testbench for eye_lineart_pixel_classifier.
// Needs elpc_pkg and the block RTL. Drives pixel words and APB writes and
// checks every class code against an in-bench predictor or a fixed class.
`timescale 1ns / 1ps

module tb_eye_lineart_pixel_classifier;
    import elpc_pkg::*;

    localparam int  RADIUS      = 35;
    localparam int  SCREEN_COLS = 240;
    localparam int  PIPE_DRAIN  = 12;
    localparam longint CYCLE_LIMIT = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [7:0]        i_pixel_x = '0;
    logic [7:0]        i_pixel_y = '0;
    logic              o_done;
    logic [2:0]        o_pixel_class;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    eye_lineart_pixel_classifier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .o_done(o_done), .o_pixel_class(o_pixel_class),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers, at their own widths.
    logic        [7:0] m_eye_cx  = 8'd82;
    logic        [7:0] m_eye_cy  = 8'd120;
    logic signed [8:0] m_pup_ox  = '0;
    logic signed [8:0] m_pup_oy  = '0;
    logic        [8:0] m_pup_sc  = 9'd256;
    logic signed [8:0] m_droop   = '0;
    logic signed [8:0] m_inner   = '0;
    logic signed [8:0] m_outer   = '0;

    logic [2:0] class_queue[$];
    int         mismatches = 0;
    longint     cycles = 0;
    int         idle_pct = 0;

    // Class of one pixel under the shadow configuration. All terms are
    // cross-multiplied so every compare is exact.
    function automatic logic [2:0] eye_class(input logic [7:0] x, input logic [7:0] y);
        longint r, fx, fy, rsq, lo, dd, arc, xt, base, top, bot, fyd;
        longint ox, oy, dx, dy, d16, p, cx, cy, ii, oo;
        r  = RADIUS;
        ii = longint'(m_inner);
        oo = longint'(m_outer);
        if (x >= SCREEN_COLS) return CLS_NONE;
        fx  = longint'(x) - longint'(m_eye_cx);
        fy  = longint'(y) - longint'(m_eye_cy);
        rsq = fx * fx + fy * fy;
        if (rsq >= r * r) return CLS_NONE;
        lo = 6400 - 40 * longint'(m_droop);
        if (lo < 256) lo = 256;
        if (lo > 6720) lo = 6720;
        dd   = 6553600 * r * r;
        arc  = r * r - fx * fx;
        xt   = 2 * r * ii + (oo - ii) * (fx + r);
        base = lo * 1024 * r * r * r;
        top  = -base + 4096 * lo * arc + 32000 * r * xt;
        bot  = base - 2560 * lo * arc - 19200 * r * xt;
        fyd  = fy * dd;
        if (fyd < top || fyd > bot) return CLS_NONE;
        ox  = longint'(m_pup_ox);
        oy  = longint'(m_pup_oy);
        dx  = 16 * fx - ox;
        dy  = 16 * fy - oy;
        d16 = dx * dx + dy * dy;
        p   = 11 * r * longint'(m_pup_sc);
        if (rsq > (r - 2) * (r - 2)) return CLS_LINE;
        if (10 * ((fyd > top) ? fyd - top : top - fyd) < 13 * dd ||
            10 * ((fyd > bot) ? fyd - bot : bot - fyd) < 13 * dd) return CLS_LINE;
        if (d16 < 64 * r * r && d16 > 64 * (r - 3) * (r - 3)) return CLS_IRIS;
        if (640000 * d16 < p * p) begin
            cx = 256000 * fx - 16000 * ox + 6 * p;
            cy = 256000 * fy - 16000 * oy + 7 * p;
            return (cx * cx + cy * cy < 49 * p * p) ? CLS_CATCH : CLS_PUPIL;
        end
        return CLS_NONE;
    endfunction

    // Monitor: an accepted word queues its class; each strobed result is
    // compared with the oldest queued class. Outputs are sampled at the
    // rising edge, before the block's own updates land.
    always @(posedge i_clk) begin
        logic [2:0] want;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (class_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: class %0d", o_pixel_class);
            end else begin
                want = class_queue.pop_front();
                if (want !== o_pixel_class) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("class mismatch: expected %0d, got %0d",
                                 want, o_pixel_class);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("eye_lineart_pixel_classifier regression: fail");
            $finish;
        end
    end

    // Writes one register through the APB port and mirrors it in the shadow.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_EYE_CX:    m_eye_cx = val[7:0];
            REG_EYE_CY:    m_eye_cy = val[7:0];
            REG_PUPIL_OX:  m_pup_ox = val[8:0];
            REG_PUPIL_OY:  m_pup_oy = val[8:0];
            REG_PUPIL_SC:  m_pup_sc = val[8:0];
            REG_LID_DROOP: m_droop  = val[8:0];
            REG_INNER_SH:  m_inner  = val[8:0];
            REG_OUTER_SH:  m_outer  = val[8:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one pixel word and holds it until the block takes it. When a
    // class is given it replaces the predicted one.
    task automatic send_pixel(input logic [7:0] x, input logic [7:0] y,
                              input int fixed_class);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do @(posedge i_clk); while (busy);
        class_queue.push_back(fixed_class >= 0 ? 3'(fixed_class) : eye_class(x, y));
        @(negedge i_clk);
    endtask

    // Lets every queued result arrive, then idles a while longer with start low.
    // Called at a falling edge, so start drops before the next rising edge.
    task automatic drain();
        start <= 1'b0;
        while (class_queue.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    // Directed words under the reset configuration; -1 means predicted.
    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        int         cls;
    } t_pixel_row;

    t_pixel_row directed_rows[20] = '{
        '{8'd0,   8'd0,   0},          // far corner, outside the eye
        '{8'd255, 8'd255, 0},          // both fields at their top
        '{8'd240, 8'd120, 0},          // first column off screen, eye row
        '{8'd239, 8'd120, 0},          // last on-screen column
        '{8'd82,  8'd255, 0},          // row 255, outside the eye
        '{8'd82,  8'd120, 3},          // dead centre is pupil
        '{8'd116, 8'd120, -1},         // outline, right side
        '{8'd48,  8'd120, -1},         // outline, left side
        '{8'd82,  8'd86,  -1},         // above the top lid
        '{8'd82,  8'd154, -1},         // below the bottom lid
        '{8'd82,  8'd107, -1},         // between pupil and iris ring, above
        '{8'd82,  8'd134, -1},         // between pupil and iris ring, below
        '{8'd99,  8'd120, -1},         // iris ring
        '{8'd65,  8'd120, -1},         // iris ring, other side
        '{8'd79,  8'd117, -1},         // catchlight area
        '{8'd80,  8'd118, -1},
        '{8'd85,  8'd122, -1},
        '{8'd82,  8'd0,   0},
        '{8'd0,   8'd120, 0},
        '{8'd170, 8'd85,  0}
    };

    // Loads a whole configuration; upper pwdata bits are random to show
    // they are ignored.
    task automatic load_config(input int kind);
        logic [31:0] v[8];
        for (int i = 0; i < 8; i++) v[i] = $urandom();
        case (kind)
            0: begin   // lowest patterns, pupil scale zero
                v[0][7:0] = 8'd0;   v[1][7:0] = 8'd0;
                v[2][8:0] = 9'h100; v[3][8:0] = 9'h100;
                v[4][8:0] = 9'd0;   v[5][8:0] = 9'h100;
                v[6][8:0] = 9'h100; v[7][8:0] = 9'h100;
            end
            1: begin   // highest patterns, lid nearly shut
                v[0][7:0] = 8'd255; v[1][7:0] = 8'd255;
                v[2][8:0] = 9'h0FF; v[3][8:0] = 9'h0FF;
                v[4][8:0] = 9'h1FF; v[5][8:0] = 9'h0FF;
                v[6][8:0] = 9'h0FF; v[7][8:0] = 9'h0FF;
            end
            default: begin   // random, eye mostly on screen
                v[0][7:0] = 8'($urandom_range(200, 40));
                v[1][7:0] = 8'($urandom_range(200, 40));
                if ($urandom_range(3) != 0) begin
                    v[5][8:0] = 9'($signed($urandom_range(80)) - 40);
                    v[4][8:0] = 9'($urandom_range(400, 100));
                end
            end
        endcase
        for (int i = 0; i < 8; i++) reg_write(3'(i), v[i]);
    endtask

    initial begin
        int dx, dy;
        logic [7:0] x, y;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].x, directed_rows[i].y, directed_rows[i].cls);
        drain();

        // Each phase gets its own configuration and sender idle rate.
        for (int ph = 0; ph < 8; ph++) begin
            load_config(ph);
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 69;
                2: idle_pct = 26;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 90; n++) begin
                // Most words land in or near the eye; the rest are anywhere.
                if ($urandom_range(9) < 8) begin
                    dx = $signed($urandom_range(74)) - 37;
                    dy = $signed($urandom_range(74)) - 37;
                    x  = 8'(int'(m_eye_cx) + dx);
                    y  = 8'(int'(m_eye_cy) + dy);
                end else begin
                    x = 8'($urandom_range(255));
                    y = 8'($urandom_range(255));
                end
                send_pixel(x, y, -1);
                // Hold off until the pipe is empty once in the middle.
                if (ph == 3 && n == 45) begin
                    start <= 1'b0;
                    while (class_queue.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        if (mismatches == 0 && class_queue.size() == 0) begin
            $display("eye_lineart_pixel_classifier regression: pass");
        end else begin
            $display("eye_lineart_pixel_classifier regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/elpc_pkg.sv
src/elpc_cfg.sv
src/eye_lineart_pixel_classifier.sv
tb/tb_eye_lineart_pixel_classifier.sv
